// ===== src/sirc_pkg.sv =====
package sirc_pkg;

  // Widths fixed by the event and result formats
  localparam int LEN_W    = 16;
  localparam int TS_W     = 32;
  localparam int WIDTH_W  = 14;
  localparam int WIN_W    = 20;
  localparam int CMD_W    = 7;
  localparam int ADDR_W   = 13;
  localparam int FBITS_W  = 5;
  // Compare width: holds 5 * 14-bit width and 4 * 16-bit length
  localparam int CMP_W    = 19;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = WIN_W;
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 3'd4;

  // Register reset values
  localparam logic [WIDTH_W-1:0] START_RST  = 14'd2400;
  localparam logic [WIDTH_W-1:0] ZERO_RST   = 14'd600;
  localparam logic [WIDTH_W-1:0] ONE_RST    = 14'd1200;
  localparam logic [WIDTH_W-1:0] SPACE_RST  = 14'd600;
  localparam logic [WIN_W-1:0]   REPEAT_RST = 20'd90000;

  // Event class handed from the front to the back
  localparam logic [1:0] CLS_SKIP = 2'd0;  // start pulse or normal space
  localparam logic [1:0] CLS_ZERO = 2'd1;
  localparam logic [1:0] CLS_ONE  = 2'd2;
  localparam logic [1:0] CLS_BAD  = 2'd3;

  typedef struct packed {
    logic [WIDTH_W-1:0] start_w;
    logic [WIDTH_W-1:0] zero_w;
    logic [WIDTH_W-1:0] one_w;
    logic [WIDTH_W-1:0] space_w;
    logic [WIN_W-1:0]   repeat_win;
  } cfg_t;

  typedef struct packed {
    logic             is_pulse;
    logic [LEN_W-1:0] length_us;
    logic             end_of_frame;
    logic [TS_W-1:0]  frame_time_us;
  } in_req_t;

  typedef struct packed {
    logic [1:0]      cls;
    logic            end_of_frame;
    logic [TS_W-1:0] frame_time_us;
  } mid_rec_t;

  typedef struct packed {
    logic               code_valid;
    logic [FBITS_W-1:0] frame_bits;
    logic [ADDR_W-1:0]  address;
    logic [CMD_W-1:0]   command;
    logic               repeat_res;
  } out_res_t;

endpackage

// ===== src/sirc_fifo.sv =====
// Small register queue, DEPTH a power of two
module sirc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== src/sirc_front.sv =====
// Front end: tracks frame start and classifies each event against the windows
module sirc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  sirc_pkg::cfg_t     cfg,
  input  sirc_pkg::in_req_t  req,
  input  logic               accept,
  output sirc_pkg::mid_rec_t rec
);
  import sirc_pkg::*;

  logic             first_seen_r, first_seen_nxt;
  logic [CMP_W-1:0] len2, len4;
  logic [CMP_W-1:0] st3, st5, z1, z5, o3, o5, s1, s3;
  logic [1:0]       cls;

  // scaled lengths and widths for exact integer window checks
  always_comb begin
    len2 = CMP_W'({req.length_us, 1'b0});
    len4 = CMP_W'({req.length_us, 2'b00});
    st3  = CMP_W'(cfg.start_w) + CMP_W'({cfg.start_w, 1'b0});
    st5  = CMP_W'(cfg.start_w) + CMP_W'({cfg.start_w, 2'b00});
    z1   = CMP_W'(cfg.zero_w);
    z5   = CMP_W'(cfg.zero_w) + CMP_W'({cfg.zero_w, 2'b00});
    o3   = CMP_W'(cfg.one_w) + CMP_W'({cfg.one_w, 1'b0});
    o5   = CMP_W'(cfg.one_w) + CMP_W'({cfg.one_w, 2'b00});
    s1   = CMP_W'(cfg.space_w);
    s3   = CMP_W'(cfg.space_w) + CMP_W'({cfg.space_w, 1'b0});
  end

  // classification: start first, then zero before one, then space
  always_comb begin
    if (!first_seen_r) begin
      cls = (req.is_pulse && len4 >= st3 && len4 <= st5) ? CLS_SKIP : CLS_BAD;
    end else if (req.is_pulse && len2 > z1 && len4 <= z5) begin
      cls = CLS_ZERO;
    end else if (req.is_pulse && len4 > o3 && len4 <= o5) begin
      cls = CLS_ONE;
    end else if (!req.is_pulse && len2 > s1 && len2 < s3) begin
      cls = CLS_SKIP;
    end else begin
      cls = CLS_BAD;
    end
  end

  assign rec.cls           = cls;
  assign rec.end_of_frame  = req.end_of_frame;
  assign rec.frame_time_us = req.frame_time_us;

  // first event of a frame is the one after an end flag
  assign first_seen_nxt = accept ? !req.end_of_frame : first_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_seen_r <= 1'b0;
    end else begin
      first_seen_r <= first_seen_nxt;
    end
  end

endmodule

// ===== src/sirc_back.sv =====
// Back end: assembles bits per frame and builds the result on the end flag
module sirc_back #(
  parameter int MAX_FRAME_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sirc_pkg::mid_rec_t           rec,
  input  logic                         rec_valid,
  output logic                         rec_take,
  input  logic [sirc_pkg::WIN_W-1:0]   repeat_win,
  input  logic                         out_full,
  output logic                         out_push,
  output sirc_pkg::out_res_t           res
);
  import sirc_pkg::*;

  logic                      err_r, err_nxt;
  logic [FBITS_W-1:0]        cnt_r, cnt_nxt;
  logic [MAX_FRAME_BITS-1:0] sh_r, sh_nxt;
  logic [MAX_FRAME_BITS-1:0] last_code_r;
  logic                      last_present_r;
  logic [TS_W-1:0]           last_time_r;
  logic                      take_bit, bit_one, ok, rep;
  logic [31:0]               v32;
  logic [TS_W-1:0]           gap;
  logic [ADDR_W-1:0]         addr_raw, addr;

  // an end record needs room in the result queue, others never stall
  assign rec_take = rec_valid && (!rec.end_of_frame || !out_full);
  assign out_push = rec_take && rec.end_of_frame;

  // frame state update for one event
  always_comb begin
    err_nxt  = err_r;
    take_bit = 1'b0;
    bit_one  = 1'b0;
    if (!err_r) begin
      unique case (rec.cls)
        CLS_ZERO: take_bit = 1'b1;
        CLS_ONE: begin
          take_bit = 1'b1;
          bit_one  = 1'b1;
        end
        CLS_SKIP: ;
        CLS_BAD:  err_nxt = 1'b1;
        default:  err_nxt = 1'b1;
      endcase
    end
    sh_nxt  = sh_r;
    cnt_nxt = cnt_r;
    if (take_bit) begin
      // LSB first; bits past the register are counted only
      for (int i = 0; i < MAX_FRAME_BITS; i++) begin
        if (bit_one && cnt_r == FBITS_W'(i)) begin
          sh_nxt[i] = 1'b1;
        end
      end
      if (cnt_r != '1) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // result: legal lengths are 12, 15 and 20 bits
  always_comb begin
    ok       = !err_nxt && (cnt_nxt == 5'd12 || cnt_nxt == 5'd15 || cnt_nxt == 5'd20);
    v32      = 32'(sh_nxt);
    gap      = rec.frame_time_us - last_time_r;
    rep      = last_present_r && (sh_nxt == last_code_r) && (gap < TS_W'(repeat_win));
    addr_raw = v32[ADDR_W+CMD_W-1:CMD_W];
    case (cnt_nxt)
      5'd12:   addr = addr_raw & 13'h001F;
      5'd15:   addr = addr_raw & 13'h00FF;
      default: addr = addr_raw;
    endcase
    res = '0;
    if (ok) begin
      res.code_valid = 1'b1;
      res.frame_bits = cnt_nxt;
      res.address    = addr;
      res.command    = v32[CMD_W-1:0];
      res.repeat_res = rep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r          <= 1'b0;
      cnt_r          <= '0;
      sh_r           <= '0;
      last_code_r    <= '0;
      last_present_r <= 1'b0;
      last_time_r    <= '0;
    end else if (rec_take) begin
      if (rec.end_of_frame) begin
        err_r       <= 1'b0;
        cnt_r       <= '0;
        sh_r        <= '0;
        last_time_r <= rec.frame_time_us;
        if (ok) begin
          last_code_r    <= sh_nxt;
          last_present_r <= 1'b1;
        end
      end else begin
        err_r <= err_nxt;
        cnt_r <= cnt_nxt;
        sh_r  <= sh_nxt;
      end
    end
  end

endmodule

// ===== src/sirc_ir_frame_decoder_top.sv =====
// IR frame decoder, one event request per cycle sustained while the result queue has room.
// Path: an accepted end-of-frame request is classified into the mid queue, then assembled from
// the mid queue head into the out queue, where its result waits to be popped.
// Throughput: 1 request per cycle; only the 2-entry result queue can stall the input.
// Reset: rst_n synchronous active low; registers return to defaults, queues empty.
module sirc_ir_frame_decoder_top #(
  parameter int MAX_FRAME_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  input  sirc_pkg::in_req_t                  in_req,
  output logic                               in_full,
  output logic                               out_empty,
  input  logic                               out_pop,
  output sirc_pkg::out_res_t                 out_res,
  input  logic                               cfg_wr_en,
  input  logic [sirc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sirc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sirc_pkg::*;

  localparam int MID_W     = $bits(mid_rec_t);
  localparam int OUT_W     = $bits(out_res_t);
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  cfg_t               cfg_r, cfg_nxt;
  mid_rec_t           mid_in, mid_head;
  logic [MID_W-1:0]   mid_head_bits;
  logic               mid_full, mid_empty, mid_take;
  logic               in_accept;
  out_res_t           back_res;
  logic [OUT_W-1:0]   out_bits;
  logic               out_full, back_push;

  // configuration registers, extra data bits dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_START:  cfg_nxt.start_w    = cfg_data[WIDTH_W-1:0];
        CFG_ZERO:   cfg_nxt.zero_w     = cfg_data[WIDTH_W-1:0];
        CFG_ONE:    cfg_nxt.one_w      = cfg_data[WIDTH_W-1:0];
        CFG_SPACE:  cfg_nxt.space_w    = cfg_data[WIDTH_W-1:0];
        CFG_REPEAT: cfg_nxt.repeat_win = cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_w    <= START_RST;
      cfg_r.zero_w     <= ZERO_RST;
      cfg_r.one_w      <= ONE_RST;
      cfg_r.space_w    <= SPACE_RST;
      cfg_r.repeat_win <= REPEAT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full   = mid_full;
  assign in_accept = in_push && !mid_full;

  sirc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .req    (in_req),
    .accept (in_accept),
    .rec    (mid_in)
  );

  // decoupling queue between classify and assemble
  sirc_fifo #(.W(MID_W), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_accept),
    .wr_data (mid_in),
    .full    (mid_full),
    .pop     (mid_take),
    .rd_data (mid_head_bits),
    .empty   (mid_empty)
  );

  assign mid_head = mid_rec_t'(mid_head_bits);

  sirc_back #(.MAX_FRAME_BITS(MAX_FRAME_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec        (mid_head),
    .rec_valid  (!mid_empty),
    .rec_take   (mid_take),
    .repeat_win (cfg_r.repeat_win),
    .out_full   (out_full),
    .out_push   (back_push),
    .res        (back_res)
  );

  // result queue
  sirc_fifo #(.W(OUT_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (back_push),
    .wr_data (back_res),
    .full    (out_full),
    .pop     (out_pop),
    .rd_data (out_bits),
    .empty   (out_empty)
  );

  assign out_res = out_res_t'(out_bits);

`ifndef SYNTH
  // invalid frames carry all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_res.code_valid) |->
      (out_res.frame_bits == '0 && out_res.address == '0 &&
       out_res.command == '0 && !out_res.repeat_res))
    else $error("invalid result has nonzero fields");

  // valid frames have a legal length
  a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_res.code_valid) |->
      (out_res.frame_bits == 5'd12 || out_res.frame_bits == 5'd15 ||
       out_res.frame_bits == 5'd20))
    else $error("valid result with illegal bit count");

  // repeat only on a valid code
  a_repeat_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_res.repeat_res) |-> out_res.code_valid)
    else $error("repeat flag on invalid result");

  // an end flag into idle queues yields a result in the output queue
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_req.end_of_frame && mid_empty && !out_full) |=> ##1 !out_empty)
    else $error("end of frame produced no result");
`endif

endmodule

// ===== sim/sirc_ir_frame_decoder_top_tb.sv =====
module sirc_ir_frame_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sirc_pkg::*;

  localparam int FRAME_BITS_MAX = 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SEG_ITEMS = 105;
  localparam int SEG_FRAMES = 4;
  localparam int HOLD_CYCLES = 400;
  // index past the register file, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;

  // Predicts decoded codes from accepted events and checks popped results
  class code_scoreboard;
    logic [WIDTH_W-1:0] start_w, zero_w, one_w, space_w;
    logic [WIN_W-1:0] repeat_win;
    bit frame_open, frame_bad;
    logic [FBITS_W-1:0] bits_seen;
    logic [FRAME_BITS_MAX-1:0] code_shift, prev_code;
    bit prev_code_ok;
    logic [TS_W-1:0] prev_time;
    out_res_t expected_codes[$];
    int errors;

    function new();
      start_w = START_RST;
      zero_w = ZERO_RST;
      one_w = ONE_RST;
      space_w = SPACE_RST;
      repeat_win = REPEAT_RST;
      prev_code = '0;
      prev_code_ok = 1'b0;
      prev_time = '0;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      frame_open = 1'b0;
      frame_bad = 1'b0;
      bits_seen = '0;
      code_shift = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_START:  start_w = data[WIDTH_W-1:0];
        CFG_ZERO:   zero_w = data[WIDTH_W-1:0];
        CFG_ONE:    one_w = data[WIDTH_W-1:0];
        CFG_SPACE:  space_w = data[WIDTH_W-1:0];
        CFG_REPEAT: repeat_win = data[WIN_W-1:0];
        default: ;
      endcase
    endfunction

    // LSB-first bit insert; count saturates, bits past the register are dropped
    function void shift_in(bit one);
      if (one && bits_seen < FRAME_BITS_MAX) code_shift[bits_seen] = 1'b1;
      if (bits_seen != 5'd31) bits_seen++;
    endfunction

    function void predict_event(in_req_t ev);
      int unsigned len, sw, zw, ow, spw, aw;
      logic [31:0] gap, mask, full;
      bit good;
      out_res_t want;
      len = ev.length_us;
      sw = start_w;
      zw = zero_w;
      ow = one_w;
      spw = space_w;
      // classify; once the frame is bad everything up to the end flag is ignored
      if (!frame_bad) begin
        if (!frame_open) begin
          if (!ev.is_pulse || 4 * len < 3 * sw || 4 * len > 5 * sw) frame_bad = 1'b1;
        end else if (ev.is_pulse && 2 * len > zw && 4 * len <= 5 * zw) begin
          shift_in(1'b0);
        end else if (ev.is_pulse && 4 * len > 3 * ow && 4 * len <= 5 * ow) begin
          shift_in(1'b1);
        end else if (!ev.is_pulse && 2 * len > spw && 2 * len < 3 * spw) begin
          // normal space, nothing to do
        end else begin
          frame_bad = 1'b1;
        end
      end
      frame_open = 1'b1;
      if (!ev.end_of_frame) return;

      // end of frame: one result, timestamp always taken
      gap = ev.frame_time_us - prev_time;
      good = !frame_bad && (bits_seen == 5'd12 || bits_seen == 5'd15 || bits_seen == 5'd20);
      prev_time = ev.frame_time_us;
      want = '0;
      if (good) begin
        aw = int'(bits_seen) - 7;
        mask = (32'd1 << aw) - 32'd1;
        full = 32'(code_shift) >> 7;
        want.code_valid = 1'b1;
        want.frame_bits = bits_seen;
        want.address = ADDR_W'(full & mask);
        want.command = code_shift[CMD_W-1:0];
        want.repeat_res = prev_code_ok && code_shift == prev_code && gap < repeat_win;
        prev_code = code_shift;
        prev_code_ok = 1'b1;
      end
      expected_codes.push_back(want);
      clear_frame();
    endfunction

    function int pending();
      return expected_codes.size();
    endfunction

    task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_code(out_res_t got);
      out_res_t want;
      if (expected_codes.size() == 0) begin
        report("result popped with no request outstanding");
        return;
      end
      want = expected_codes.pop_front();
      compare_field("code_valid", 32'(got.code_valid), 32'(want.code_valid));
      compare_field("frame_bits", 32'(got.frame_bits), 32'(want.frame_bits));
      compare_field("address", 32'(got.address), 32'(want.address));
      compare_field("command", 32'(got.command), 32'(want.command));
      compare_field("repeat_res", 32'(got.repeat_res), 32'(want.repeat_res));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  in_req_t in_req = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  out_res_t out_res;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_START;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  code_scoreboard sb = new();

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_hold_req = 1'b0;
  int items = 0;
  int frames_sent = 0;
  int cycle_count = 0;
  logic [31:0] last_eof_ts = '0;
  int last_good_bits = 0;
  logic [31:0] last_good_code = '0;
  in_req_t frame_q[$];

  sirc_ir_frame_decoder_top #(
    .MAX_FRAME_BITS(FRAME_BITS_MAX)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_req(in_req),
    .in_full(in_full),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_res(out_res),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sirc_ir_frame_decoder_top_tb: done, errors");
    $finish;
  end

  // Result side: pop with random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) sb.check_code(out_res);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // One event request, held until accepted
  task send_event(in_req_t ev);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_req <= ev;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.predict_event(ev);
    items++;
  endtask

  function void add_event(bit pulse, int unsigned len);
    in_req_t ev;
    ev.is_pulse = pulse;
    ev.length_us = len[LEN_W-1:0];
    ev.end_of_frame = 1'b0;
    ev.frame_time_us = $urandom;
    frame_q.push_back(ev);
  endfunction

  // Flag the last event, stamp the frame and send it
  task finish_frame(logic [31:0] ts);
    frame_q[$].end_of_frame = 1'b1;
    frame_q[$].frame_time_us = ts;
    last_eof_ts = ts;
    foreach (frame_q[i]) send_event(frame_q[i]);
    frame_q.delete();
    frames_sent++;
  endtask

  // Accept window for one event class under the current settings
  function void window(logic [CFG_IDX_W-1:0] idx, output int unsigned lo,
                       output int unsigned hi);
    int unsigned w;
    case (idx)
      CFG_START: begin
        w = sb.start_w;
        lo = (3 * w + 3) / 4;
        hi = 5 * w / 4;
      end
      CFG_ZERO: begin
        w = sb.zero_w;
        lo = w / 2 + 1;
        hi = 5 * w / 4;
      end
      CFG_ONE: begin
        w = sb.one_w;
        lo = 3 * w / 4 + 1;
        hi = 5 * w / 4;
      end
      default: begin
        w = sb.space_w;
        lo = w / 2 + 1;
        hi = (3 * w - 1) / 2;
      end
    endcase
  endfunction

  // Length inside a window, edges favored
  function int unsigned good_len(logic [CFG_IDX_W-1:0] idx);
    int unsigned lo, hi, r;
    window(idx, lo, hi);
    r = $urandom_range(0, 9);
    if (hi < lo || r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  // Random event, either any length or just outside some window
  function void add_noise();
    int unsigned lo, hi;
    logic [CFG_IDX_W-1:0] idx;
    if ($urandom_range(0, 1) == 0) begin
      add_event(1'($urandom_range(0, 1)), $urandom_range(0, 65535));
    end else begin
      case ($urandom_range(0, 3))
        0: idx = CFG_START;
        1: idx = CFG_ZERO;
        2: idx = CFG_ONE;
        default: idx = CFG_SPACE;
      endcase
      window(idx, lo, hi);
      add_event(1'($urandom_range(0, 1)), $urandom_range(0, 1) ? lo - 1 : hi + 1);
    end
  endfunction

  function void build_bits(int nbits, logic [31:0] code, int space_pct);
    add_event(1'b1, good_len(CFG_START));
    for (int i = 0; i < nbits; i++) begin
      if ($urandom_range(0, 99) < space_pct) add_event(1'b0, good_len(CFG_SPACE));
      add_event(1'b1, good_len(code[i & 31] ? CFG_ONE : CFG_ZERO));
    end
  endfunction

  // Frame stamp: random, near the repeat window edge, or a gap of up to twice the window plus 16
  function logic [31:0] next_frame_ts();
    int unsigned win, r;
    win = sb.repeat_win;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom;
    if (r < 40) return last_eof_ts + win - 1 + $urandom_range(0, 2);
    return last_eof_ts + $urandom_range(0, 2 * win + 16);
  endfunction

  function int legal_bits();
    int r;
    r = $urandom_range(0, 99);
    return (r < 50) ? 12 : (r < 80) ? 15 : 20;
  endfunction

  task random_frame();
    int kind, nbits, idx;
    logic [31:0] code;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      // well-formed, often the same code again
      if (last_good_bits != 0 && $urandom_range(0, 99) < 30) begin
        nbits = last_good_bits;
        code = last_good_code;
      end else begin
        nbits = legal_bits();
        code = $urandom & ((32'd1 << nbits) - 32'd1);
      end
      build_bits(nbits, code, $urandom_range(0, 100));
      last_good_bits = nbits;
      last_good_code = code;
    end else if (kind < 75) begin
      // clean structure, any bit count including saturation
      build_bits($urandom_range(0, 33), $urandom, 50);
    end else if (kind < 90) begin
      // one event replaced by noise
      build_bits(legal_bits(), $urandom, 50);
      idx = $urandom_range(0, frame_q.size() - 1);
      add_noise();
      frame_q[idx] = frame_q.pop_back();
    end else begin
      repeat ($urandom_range(1, 6)) add_noise();
    end
    if ($urandom_range(0, 99) < 20) add_event(1'b0, good_len(CFG_SPACE));
    finish_frame(next_frame_ts());
  endtask

  task send_directed();
    logic [11:0] code;
    code = 12'hB4D;
    // lone events: zero length, full length space, full length pulse, bare start
    add_event(1'b1, 0);
    finish_frame(32'h0);
    add_event(1'b0, 65535);
    finish_frame(32'hFFFF_FFFF);
    add_event(1'b1, 65535);
    finish_frame(32'h0);
    add_event(1'b1, 2400);
    finish_frame(32'h10);
    // first valid code, no spaces, window edges on every pulse
    add_event(1'b1, 1800);
    for (int i = 0; i < 12; i++) begin
      if (code[i]) add_event(1'b1, (i % 2) ? 901 : 1500);
      else add_event(1'b1, (i % 2) ? 301 : 750);
    end
    finish_frame(32'd1000);
    // bad pulse after a top-edge start, rest of the frame ignored
    add_event(1'b1, 3000);
    add_event(1'b1, 0);
    add_event(1'b0, 65535);
    finish_frame(32'd90999);
  endtask

  task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // width registers get junk above bit 13, which must be dropped
  task write_regs(int unsigned s, int unsigned z, int unsigned o, int unsigned sp,
                  int unsigned win);
    cfg_write(CFG_START, {6'($urandom), 14'(s)});
    cfg_write(CFG_ZERO, {6'($urandom), 14'(z)});
    cfg_write(CFG_ONE, {6'($urandom), 14'(o)});
    cfg_write(CFG_SPACE, {6'($urandom), 14'(sp)});
    cfg_write(CFG_REPEAT, 20'(win));
  endtask

  task apply_settings(int seg);
    int unsigned z;
    case (seg)
      0: ;
      1: begin
        cfg_write(CFG_IDX_NONE, 20'($urandom));
        write_regs(16383, 8000, 16383, 16383, 1000000);
      end
      2: write_regs(1, 1, 1, 1, 0);
      3: write_regs($urandom_range(1, 16383), $urandom_range(1, 16383),
                    $urandom_range(1, 16383), $urandom_range(1, 16383),
                    $urandom_range(0, 1000000));
      4: write_regs(START_RST, ZERO_RST, ONE_RST, SPACE_RST, REPEAT_RST);
      default: begin
        z = $urandom_range(50, 3000);
        write_regs(4 * z, z, 2 * z + $urandom_range(0, 50), $urandom_range(50, 3000),
                   $urandom_range(0, 1000000));
      end
    endcase
    cfg_wr_en <= 1'b0;
  endtask

  // Stop sending and let every outstanding result come out
  task drain();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    int seg_items, seg_frames;
    bit hold_asked;
    hold_asked = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 19;
    rx_idle_pct = 65;
    send_directed();

    for (int seg = 0; seg < 6; seg++) begin
      if (seg > 0) drain();
      apply_settings(seg);
      case (seg / 2)
        0: begin
          tx_idle_pct = 19;
          rx_idle_pct = 65;
        end
        1: begin
          tx_idle_pct = 65;
          rx_idle_pct = 19;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      seg_items = items;
      seg_frames = frames_sent;
      while (items - seg_items < SEG_ITEMS || frames_sent - seg_frames < SEG_FRAMES) begin
        // long receiver hold-off while requests keep coming
        if (seg == 1 && !hold_asked && items - seg_items > 20) begin
          hold_asked = 1'b1;
          rx_hold_req = 1'b1;
        end
        random_frame();
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("sirc_ir_frame_decoder_top_tb: done, clean");
    end else begin
      $display("sirc_ir_frame_decoder_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sirc_pkg.sv
src/sirc_fifo.sv
src/sirc_front.sv
src/sirc_back.sv
src/sirc_ir_frame_decoder_top.sv
sim/sirc_ir_frame_decoder_top_tb.sv
